// ===== src/display_list_command_processor_macros.svh =====
// ----------------------------------------------------------------------------
// Display list command processor assertion macros
// Clocked, reset-qualified assertion forms shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef DISPLAY_LIST_COMMAND_PROCESSOR_MACROS_SVH
`define DISPLAY_LIST_COMMAND_PROCESSOR_MACROS_SVH

// check a condition at every clock edge out of reset
`define DLCP_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check a consequence in the cycle after its trigger
`define DLCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dlcp_pkg.sv =====
// ----------------------------------------------------------------------------
// Display list command processor package
// Opcodes, register indexes, shared types and the address remap function.
// ----------------------------------------------------------------------------
package dlcp_pkg;

    localparam logic [7:0] OP_VADDR  = 8'h01;
    localparam logic [7:0] OP_IADDR  = 8'h02;
    localparam logic [7:0] OP_PRIM   = 8'h04;
    localparam logic [7:0] OP_JUMP   = 8'h08;
    localparam logic [7:0] OP_CALL   = 8'h0A;
    localparam logic [7:0] OP_RET    = 8'h0B;
    localparam logic [7:0] OP_END    = 8'h0C;
    localparam logic [7:0] OP_BASE   = 8'h10;
    localparam logic [7:0] OP_VTYPE  = 8'h12;
    localparam logic [7:0] OP_OFFSET = 8'h13;
    localparam logic [7:0] OP_ORIGIN = 8'h14;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_VRAM_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VRAM_HIGH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAIN_LOW  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAIN_HIGH = 2'd3;

    localparam logic [31:0] VRAM_LOW_RESET  = 32'h0400_0000;
    localparam logic [31:0] VRAM_HIGH_RESET = 32'h041F_FFFF;
    localparam logic [31:0] MAIN_LOW_RESET  = 32'h0800_0000;
    localparam logic [31:0] MAIN_HIGH_RESET = 32'h09FF_FFFF;

    localparam logic [31:0] ALIGN_MASK  = 32'hFFFF_FFFC;
    localparam logic [31:0] VRAM_PREFIX = 32'h4400_0000;
    localparam logic [31:0] LOW30_MASK  = 32'h3FFF_FFFF;

    typedef struct packed {
        logic [31:0] ret_addr;
        logic [31:0] offset;
    } stack_entry_t;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stack_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } stack_stat_t;

    function automatic logic [31:0] remap(
        input logic [31:0] a,
        input logic [31:0] vram_low,
        input logic [31:0] vram_high,
        input logic [31:0] main_low,
        input logic [31:0] main_high
    );
        logic [31:0] v;
        logic [31:0] m;
        begin
            v = ((a >= vram_low) && (a < vram_high)) ? (VRAM_PREFIX | (a & LOW30_MASK)) : a;
            m = ((v >= main_low) && (v < main_high)) ? (main_low | (v & LOW30_MASK)) : v;
            return m;
        end
    endfunction

endpackage

// ===== src/dlcp_stack.sv =====
// ----------------------------------------------------------------------------
// Display list call stack
// Return address and offset pairs in a synchronous memory, with the top entry
// held in a register and refilled from the memory in the cycle after a pop.
// ----------------------------------------------------------------------------
module dlcp_stack #(
    parameter int CALL_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dlcp_pkg::stack_req_t  req,
    input  dlcp_pkg::stack_entry_t push_entry,
    output dlcp_pkg::stack_entry_t tos,
    output dlcp_pkg::stack_stat_t stat
);

    localparam int DW   = $clog2(CALL_DEPTH + 1);
    localparam int IDXW = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

    dlcp_pkg::stack_entry_t mem [CALL_DEPTH];

    logic [DW-1:0]          depth_reg;
    logic [DW-1:0]          depth_next;
    logic [DW-1:0]          depth_m2;
    logic                   sel_reg;
    logic                   sel_next;
    dlcp_pkg::stack_entry_t tos_reg;
    dlcp_pkg::stack_entry_t rd_data_reg;

    assign depth_m2   = depth_reg - DW'(2);
    assign tos        = sel_reg ? rd_data_reg : tos_reg;
    assign stat.full  = (depth_reg == DW'(CALL_DEPTH));
    assign stat.empty = (depth_reg == '0);

    always_comb
    begin
        depth_next = depth_reg;
        sel_next   = sel_reg;
        if (req.clear)
        begin
            depth_next = '0;
        end
        else if (req.push)
        begin
            depth_next = depth_reg + DW'(1);
            sel_next   = 1'b0;
        end
        else if (req.pop)
        begin
            depth_next = depth_reg - DW'(1);
            sel_next   = 1'b1;
        end
        else
        begin
            sel_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            depth_reg <= depth_next;
            sel_reg   <= sel_next;
        end
    end

    // hold the top entry; fold in refill data once no further pop follows
    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            tos_reg <= push_entry;
        end
        else if (sel_reg && !req.pop)
        begin
            tos_reg <= rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
        begin
            mem[depth_reg[IDXW-1:0]] <= push_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.pop)
        begin
            rd_data_reg <= mem[depth_m2[IDXW-1:0]];
        end
    end

endmodule

// ===== src/display_list_command_processor.sv =====
// ----------------------------------------------------------------------------
// Display list command processor
// Walks a display list one command word per request: flow control, call
// stack, base and offset, array address remap and primitive/vertex decode.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_stall   | action, list_start, command_word
//  out      | out_valid / out_stall | next_fetch ... through_mode (one per in)
//  cfg      | cfg_write             | cfg_index, cfg_data (window bounds)
//
//  One request per cycle unless stalled; results pass stage 1, then the outputs.
//  The fetch pointer, base and call stack update in the accept cycle; a
//  return reads its top entry from a register refilled by the stack memory.
//  Array addresses are remapped in the second stage.
//  Reset is asynchronous; no list is active after reset.
//  A stalled output holds its result; input stalls only when both stages hold.
// ----------------------------------------------------------------------------
`include "display_list_command_processor_macros.svh"

module display_list_command_processor #(
    parameter int CALL_DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [dlcp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [31:0]                      list_start,
    input  logic [31:0]                      command_word,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [31:0]                      next_fetch,
    output logic                             list_done,
    output logic                             stack_fault,
    output logic [31:0]                      vertex_base,
    output logic [31:0]                      index_base,
    output logic                             prim_valid,
    output logic [15:0]                      prim_vertex_count,
    output logic [2:0]                       prim_kind,
    output logic [23:0]                      vertex_format,
    output logic [3:0]                       skin_weight_count,
    output logic [3:0]                       morph_count,
    output logic                             through_mode
);

    logic [31:0] vram_low_reg;
    logic [31:0] vram_high_reg;
    logic [31:0] main_low_reg;
    logic [31:0] main_high_reg;

    logic [31:0] fp_reg;
    logic [31:0] fp_next;
    logic [7:0]  base_reg;
    logic [7:0]  base_next;
    logic [31:0] off_reg;
    logic [31:0] off_next;
    logic [23:0] vtype_reg;
    logic [23:0] vtype_next;
    logic        halted_reg;
    logic        halted_next;

    logic        s1_valid_reg;
    logic [31:0] s1_fetch_reg;
    logic        s1_done_reg;
    logic        s1_fault_reg;
    logic        s1_prim_reg;
    logic [15:0] s1_count_reg;
    logic [2:0]  s1_kind_reg;
    logic [23:0] s1_vtype_reg;
    logic        s1_clear_reg;
    logic        s1_upd_v_reg;
    logic        s1_upd_i_reg;
    logic [31:0] s1_raw_reg;

    logic [31:0] vaddr_reg;
    logic [31:0] vaddr_next;
    logic [31:0] iaddr_reg;
    logic [31:0] iaddr_next;
    logic [31:0] remapped;

    logic        out_valid_reg;
    logic        out_valid_next;

    logic        accept;
    logic        move1;
    logic        active;
    logic [7:0]  op;
    logic [23:0] arg;
    logic [31:0] seq;
    logic [31:0] form;
    logic        done_c;
    logic        fault_c;
    logic        prim_c;
    logic        upd_v_c;
    logic        upd_i_c;

    dlcp_pkg::stack_req_t   stk_req;
    dlcp_pkg::stack_entry_t stk_push;
    dlcp_pkg::stack_entry_t stk_tos;
    dlcp_pkg::stack_stat_t  stk_stat;

    assign move1    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !move1;
    assign accept   = in_valid && !in_stall;
    assign active   = accept && action && !halted_reg;

    assign op   = command_word[31:24];
    assign arg  = command_word[23:0];
    assign seq  = fp_reg + 32'd4;
    assign form = {base_reg, arg} + off_reg;

    assign stk_push.ret_addr = seq;
    assign stk_push.offset   = off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vram_low_reg  <= dlcp_pkg::VRAM_LOW_RESET;
            vram_high_reg <= dlcp_pkg::VRAM_HIGH_RESET;
            main_low_reg  <= dlcp_pkg::MAIN_LOW_RESET;
            main_high_reg <= dlcp_pkg::MAIN_HIGH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dlcp_pkg::CFG_VRAM_LOW:  vram_low_reg  <= cfg_data;
                dlcp_pkg::CFG_VRAM_HIGH: vram_high_reg <= cfg_data;
                dlcp_pkg::CFG_MAIN_LOW:  main_low_reg  <= cfg_data;
                dlcp_pkg::CFG_MAIN_HIGH: main_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        fp_next     = fp_reg;
        base_next   = base_reg;
        off_next    = off_reg;
        vtype_next  = vtype_reg;
        halted_next = halted_reg;
        done_c      = 1'b0;
        fault_c     = 1'b0;
        prim_c      = 1'b0;
        upd_v_c     = 1'b0;
        upd_i_c     = 1'b0;
        stk_req     = '0;
        if (accept && !action)
        begin
            fp_next       = list_start;
            base_next     = '0;
            off_next      = '0;
            vtype_next    = '0;
            halted_next   = 1'b0;
            stk_req.clear = 1'b1;
        end
        else if (active)
        begin
            fp_next = seq;
            case (op)
                dlcp_pkg::OP_END:
                begin
                    halted_next = 1'b1;
                    done_c      = 1'b1;
                end
                dlcp_pkg::OP_JUMP:   fp_next = form & dlcp_pkg::ALIGN_MASK;
                dlcp_pkg::OP_CALL:
                begin
                    if (stk_stat.full)
                    begin
                        fault_c = 1'b1;
                    end
                    else
                    begin
                        stk_req.push = 1'b1;
                        fp_next      = form & dlcp_pkg::ALIGN_MASK;
                    end
                end
                dlcp_pkg::OP_RET:
                begin
                    if (stk_stat.empty)
                    begin
                        fault_c = 1'b1;
                    end
                    else
                    begin
                        stk_req.pop = 1'b1;
                        fp_next     = stk_tos.ret_addr;
                        off_next    = stk_tos.offset;
                    end
                end
                dlcp_pkg::OP_BASE:   base_next  = arg[23:16];
                dlcp_pkg::OP_OFFSET: off_next   = {arg, 8'h00};
                dlcp_pkg::OP_ORIGIN: off_next   = fp_reg;
                dlcp_pkg::OP_VADDR:  upd_v_c    = 1'b1;
                dlcp_pkg::OP_IADDR:  upd_i_c    = 1'b1;
                dlcp_pkg::OP_PRIM:   prim_c     = 1'b1;
                dlcp_pkg::OP_VTYPE:  vtype_next = arg;
                default: ;
            endcase
        end
    end

    dlcp_stack #(
        .CALL_DEPTH (CALL_DEPTH)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (stk_req),
        .push_entry (stk_push),
        .tos        (stk_tos),
        .stat       (stk_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg        <= '0;
            base_reg      <= '0;
            off_reg       <= '0;
            vtype_reg     <= '0;
            halted_reg    <= 1'b1;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vaddr_reg     <= '0;
            iaddr_reg     <= '0;
        end
        else
        begin
            fp_reg        <= fp_next;
            base_reg      <= base_next;
            off_reg       <= off_next;
            vtype_reg     <= vtype_next;
            halted_reg    <= halted_next;
            s1_valid_reg  <= accept || (s1_valid_reg && !move1);
            out_valid_reg <= out_valid_next;
            vaddr_reg     <= vaddr_next;
            iaddr_reg     <= iaddr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_fetch_reg <= fp_next;
            s1_done_reg  <= done_c;
            s1_fault_reg <= fault_c;
            s1_prim_reg  <= prim_c;
            s1_count_reg <= prim_c ? arg[15:0] : 16'd0;
            s1_kind_reg  <= prim_c ? arg[18:16] : 3'd0;
            s1_vtype_reg <= vtype_next;
            s1_clear_reg <= !action;
            s1_upd_v_reg <= upd_v_c;
            s1_upd_i_reg <= upd_i_c;
            s1_raw_reg   <= form;
        end
    end

    assign remapped = dlcp_pkg::remap(s1_raw_reg, vram_low_reg, vram_high_reg,
                                      main_low_reg, main_high_reg);

    always_comb
    begin
        vaddr_next = vaddr_reg;
        iaddr_next = iaddr_reg;
        if (move1)
        begin
            if (s1_clear_reg)
            begin
                vaddr_next = '0;
                iaddr_next = '0;
            end
            else
            begin
                if (s1_upd_v_reg)
                begin
                    vaddr_next = remapped;
                end
                if (s1_upd_i_reg)
                begin
                    iaddr_next = remapped;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move1)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            next_fetch        <= s1_fetch_reg;
            list_done         <= s1_done_reg;
            stack_fault       <= s1_fault_reg;
            vertex_base       <= vaddr_next;
            index_base        <= iaddr_next;
            prim_valid        <= s1_prim_reg;
            prim_vertex_count <= s1_count_reg;
            prim_kind         <= s1_kind_reg;
            vertex_format     <= s1_vtype_reg;
            skin_weight_count <= {1'b0, s1_vtype_reg[16:14]} + 4'd1;
            morph_count       <= {1'b0, s1_vtype_reg[20:18]} + 4'd1;
            through_mode      <= s1_vtype_reg[23];
        end
    end

    assign out_valid = out_valid_reg;

    `DLCP_ASSERT_NEXT(a_push_tos, stk_req.push, stk_tos.ret_addr == $past(seq), "call not on stack top")
    `DLCP_ASSERT_NEXT(a_end_halts, active && (op == dlcp_pkg::OP_END), halted_reg, "end did not halt")
    `DLCP_ASSERT_NEXT(a_halted_hold, accept && action && halted_reg, $stable(fp_reg), "pointer moved while halted")

endmodule

// ===== bench/tb_display_list_command_processor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Display list command processor testbench
// Walks random and directed display lists through the block with stalls on
// both channels, predicts every result from its own model of the fetch
// pointer, call stack, base/offset and window remap, and checks each result
// in order, over several memory window settings.
// ----------------------------------------------------------------------------
module tb_display_list_command_processor;

    localparam int CLK_PERIOD     = 4;
    localparam int CALL_LIMIT     = 32;
    localparam int CALL_IDX_W     = $clog2(CALL_LIMIT);
    localparam int HOLD_CYCLES    = 48;
    localparam int SETTLE_CYCLES  = 4;
    localparam int QUIET_LIMIT    = 1000;
    localparam int END_LIMIT      = 200;
    localparam logic [7:0] OP_COND_JUMP = 8'h09;
    localparam logic [7:0] OP_UNUSED    = 8'hFF;

    typedef struct packed {
        logic [31:0] next_fetch;
        logic        list_done;
        logic        stack_fault;
        logic [31:0] vertex_base;
        logic [31:0] index_base;
        logic        prim_valid;
        logic [15:0] prim_vertex_count;
        logic [2:0]  prim_kind;
        logic [23:0] vertex_format;
        logic [3:0]  skin_weight_count;
        logic [3:0]  morph_count;
        logic        through_mode;
    } dl_result_t;

    class list_walk_checker;
        logic [31:0] win_vram_low;
        logic [31:0] win_vram_high;
        logic [31:0] win_main_low;
        logic [31:0] win_main_high;
        logic [31:0] fetch_ptr;
        logic [7:0]  top_byte;
        logic [31:0] list_offset;
        logic [31:0] return_addr [CALL_LIMIT];
        logic [31:0] saved_offset [CALL_LIMIT];
        int unsigned call_depth;
        logic [31:0] vertex_addr;
        logic [31:0] index_addr;
        logic [23:0] vtype_word;
        bit          stopped;
        dl_result_t  pending_results[$];
        int          error_count;
        int          live_count;
        int          start_count;
        int          call_count;
        int          fault_count;
        int          prim_count;

        function new();
            win_vram_low  = dlcp_pkg::VRAM_LOW_RESET;
            win_vram_high = dlcp_pkg::VRAM_HIGH_RESET;
            win_main_low  = dlcp_pkg::MAIN_LOW_RESET;
            win_main_high = dlcp_pkg::MAIN_HIGH_RESET;
            fetch_ptr     = '0;
            clear_list();
            stopped       = 1'b1;
        endfunction

        function void clear_list();
            top_byte    = '0;
            list_offset = '0;
            call_depth  = 0;
            vertex_addr = '0;
            index_addr  = '0;
            vtype_word  = '0;
        endfunction

        function void set_window(logic [dlcp_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
            case (idx)
                dlcp_pkg::CFG_VRAM_LOW:  win_vram_low  = value;
                dlcp_pkg::CFG_VRAM_HIGH: win_vram_high = value;
                dlcp_pkg::CFG_MAIN_LOW:  win_main_low  = value;
                dlcp_pkg::CFG_MAIN_HIGH: win_main_high = value;
                default: ;
            endcase
        endfunction

        function logic [31:0] form_address(logic [23:0] arg);
            return {top_byte, arg} + list_offset;
        endfunction

        function logic [31:0] window_map(logic [31:0] a);
            logic [31:0] m;
            m = a;
            if (m >= win_vram_low && m < win_vram_high)
                m = dlcp_pkg::VRAM_PREFIX | (m & dlcp_pkg::LOW30_MASK);
            if (m >= win_main_low && m < win_main_high)
                m = win_main_low | (m & dlcp_pkg::LOW30_MASK);
            return m;
        endfunction

        function void note_request(bit act, logic [31:0] start, logic [31:0] word);
            dl_result_t  r;
            logic [7:0]  op;
            logic [23:0] arg;
            logic [31:0] here;
            r   = '0;
            op  = word[31:24];
            arg = word[23:0];
            if (!act)
            begin
                clear_list();
                fetch_ptr = start;
                stopped   = 1'b0;
                live_count++;
                start_count++;
            end
            else if (!stopped)
            begin
                live_count++;
                here      = fetch_ptr;
                fetch_ptr = here + 32'd4;
                case (op)
                    dlcp_pkg::OP_END:
                    begin
                        stopped     = 1'b1;
                        r.list_done = 1'b1;
                    end
                    dlcp_pkg::OP_JUMP:
                        fetch_ptr = form_address(arg) & dlcp_pkg::ALIGN_MASK;
                    dlcp_pkg::OP_CALL:
                    begin
                        call_count++;
                        if (call_depth >= CALL_LIMIT)
                        begin
                            r.stack_fault = 1'b1;
                        end
                        else
                        begin
                            return_addr[call_depth[CALL_IDX_W-1:0]]  = fetch_ptr;
                            saved_offset[call_depth[CALL_IDX_W-1:0]] = list_offset;
                            call_depth++;
                            fetch_ptr = form_address(arg) & dlcp_pkg::ALIGN_MASK;
                        end
                    end
                    dlcp_pkg::OP_RET:
                    begin
                        if (call_depth == 0)
                        begin
                            r.stack_fault = 1'b1;
                        end
                        else
                        begin
                            call_depth--;
                            fetch_ptr   = return_addr[call_depth[CALL_IDX_W-1:0]];
                            list_offset = saved_offset[call_depth[CALL_IDX_W-1:0]];
                        end
                    end
                    dlcp_pkg::OP_BASE:   top_byte    = arg[23:16];
                    dlcp_pkg::OP_OFFSET: list_offset = {arg, 8'h00};
                    dlcp_pkg::OP_ORIGIN: list_offset = here;
                    dlcp_pkg::OP_VADDR:  vertex_addr = window_map(form_address(arg));
                    dlcp_pkg::OP_IADDR:  index_addr  = window_map(form_address(arg));
                    dlcp_pkg::OP_PRIM:
                    begin
                        r.prim_valid        = 1'b1;
                        r.prim_vertex_count = arg[15:0];
                        r.prim_kind         = arg[18:16];
                        prim_count++;
                    end
                    dlcp_pkg::OP_VTYPE:  vtype_word = arg;
                    default: ;
                endcase
                if (r.stack_fault)
                    fault_count++;
            end
            r.next_fetch        = fetch_ptr;
            r.vertex_base       = vertex_addr;
            r.index_base        = index_addr;
            r.vertex_format     = vtype_word;
            r.skin_weight_count = {1'b0, vtype_word[16:14]} + 4'd1;
            r.morph_count       = {1'b0, vtype_word[20:18]} + 4'd1;
            r.through_mode      = vtype_word[23];
            pending_results.push_back(r);
        endfunction

        task report_error(string msg);
            error_count++;
            $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_error($sformatf("%s: got %h, expected %h", name, got, want));
        endtask

        task check_result(dl_result_t got);
            dl_result_t want;
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("result with no request pending, next_fetch %h",
                                       got.next_fetch));
                return;
            end
            want = pending_results.pop_front();
            compare_field("next_fetch", got.next_fetch, want.next_fetch);
            compare_field("list_done", 32'(got.list_done), 32'(want.list_done));
            compare_field("stack_fault", 32'(got.stack_fault), 32'(want.stack_fault));
            compare_field("vertex_base", got.vertex_base, want.vertex_base);
            compare_field("index_base", got.index_base, want.index_base);
            compare_field("prim_valid", 32'(got.prim_valid), 32'(want.prim_valid));
            compare_field("prim_vertex_count", 32'(got.prim_vertex_count),
                          32'(want.prim_vertex_count));
            compare_field("prim_kind", 32'(got.prim_kind), 32'(want.prim_kind));
            compare_field("vertex_format", 32'(got.vertex_format),
                          32'(want.vertex_format));
            compare_field("skin_weight_count", 32'(got.skin_weight_count),
                          32'(want.skin_weight_count));
            compare_field("morph_count", 32'(got.morph_count), 32'(want.morph_count));
            compare_field("through_mode", 32'(got.through_mode), 32'(want.through_mode));
        endtask
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_write = 1'b0;
    logic [dlcp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0]                      cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             action = 1'b0;
    logic [31:0]                      list_start = '0;
    logic [31:0]                      command_word = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [31:0]                      next_fetch;
    logic                             list_done;
    logic                             stack_fault;
    logic [31:0]                      vertex_base;
    logic [31:0]                      index_base;
    logic                             prim_valid;
    logic [15:0]                      prim_vertex_count;
    logic [2:0]                       prim_kind;
    logic [23:0]                      vertex_format;
    logic [3:0]                       skin_weight_count;
    logic [3:0]                       morph_count;
    logic                             through_mode;

    list_walk_checker sb = new();
    dl_result_t       seen;
    bit               idle_on = 1'b1;
    bit               hold_request = 1'b0;
    int               stall_left = 0;
    int unsigned      quiet_cycles = 0;
    int               window_settings = 1;
    int               end_wait;

    display_list_command_processor #(
        .CALL_DEPTH(CALL_LIMIT)
    ) dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .action            (action),
        .list_start        (list_start),
        .command_word      (command_word),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .next_fetch        (next_fetch),
        .list_done         (list_done),
        .stack_fault       (stack_fault),
        .vertex_base       (vertex_base),
        .index_base        (index_base),
        .prim_valid        (prim_valid),
        .prim_vertex_count (prim_vertex_count),
        .prim_kind         (prim_kind),
        .vertex_format     (vertex_format),
        .skin_weight_count (skin_weight_count),
        .morph_count       (morph_count),
        .through_mode      (through_mode)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // collect results, then pick the next stall value
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen = '{next_fetch, list_done, stack_fault, vertex_base, index_base,
                     prim_valid, prim_vertex_count, prim_kind, vertex_format,
                     skin_weight_count, morph_count, through_mode};
            sb.check_result(seen);
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("display_list_command_processor test failed");
        $finish;
    end

    task automatic send_request(bit act, logic [31:0] start, logic [31:0] word);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        list_start   <= start;
        command_word <= word;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(act, start, word);
    endtask

    task automatic send_cmd(logic [31:0] word);
        send_request(1'b1, $urandom, word);
    endtask

    task automatic start_list(logic [31:0] addr);
        send_request(1'b0, addr, $urandom);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [dlcp_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_window(idx, value);
    endtask

    task automatic program_windows(logic [31:0] vram_lo, logic [31:0] vram_hi,
                                   logic [31:0] main_lo, logic [31:0] main_hi);
        drain_results();
        write_register(dlcp_pkg::CFG_VRAM_LOW, vram_lo);
        write_register(dlcp_pkg::CFG_VRAM_HIGH, vram_hi);
        write_register(dlcp_pkg::CFG_MAIN_LOW, main_lo);
        write_register(dlcp_pkg::CFG_MAIN_HIGH, main_hi);
        cfg_write <= 1'b0;
        @(posedge clk);
        window_settings++;
    endtask

    function automatic logic [7:0] pick_top_byte();
        case ($urandom_range(0, 5))
            0: return 8'h04;
            1: return 8'h08;
            2: return 8'h09;
            3: return 8'h44;
            4: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_start();
        logic [31:0] s;
        s = $urandom;
        if ($urandom_range(0, 1))
            s[1:0] = 2'b00;
        if ($urandom_range(0, 15) == 0)
            s[31:8] = 24'hFF_FFFF;
        return s;
    endfunction

    function automatic logic [31:0] rand_command();
        int          pick;
        logic [23:0] arg;
        pick = $urandom_range(0, 99);
        arg  = 24'($urandom);
        if (pick < 24 && $urandom_range(0, 1))
            arg = arg & 24'h1F_FFFF;
        if (pick < 12) return {dlcp_pkg::OP_VADDR, arg};
        if (pick < 22) return {dlcp_pkg::OP_IADDR, arg};
        if (pick < 34) return {dlcp_pkg::OP_PRIM, arg};
        if (pick < 42) return {dlcp_pkg::OP_VTYPE, arg};
        if (pick < 50) return {dlcp_pkg::OP_BASE, pick_top_byte(), arg[15:0]};
        if (pick < 55) return {dlcp_pkg::OP_OFFSET, 24'($urandom_range(0, 24'h00_0FFF))};
        if (pick < 59) return {dlcp_pkg::OP_ORIGIN, arg};
        if (pick < 64) return {dlcp_pkg::OP_JUMP, arg};
        if (pick < 70) return {dlcp_pkg::OP_CALL, arg};
        if (pick < 76) return {dlcp_pkg::OP_RET, arg};
        if (pick < 79) return {dlcp_pkg::OP_END, arg};
        if (pick < 84) return {OP_COND_JUMP, arg};
        return $urandom;
    endfunction

    task automatic directed_items();
        send_cmd({dlcp_pkg::OP_PRIM, 24'h00_0000});
        start_list(32'hFFFF_FFFF);
        send_cmd({dlcp_pkg::OP_RET, 24'h00_0000});
        start_list(32'h0000_0000);
        send_cmd({dlcp_pkg::OP_BASE, 24'hFF_0000});
        send_cmd({dlcp_pkg::OP_OFFSET, 24'hFF_FFFF});
        send_cmd({dlcp_pkg::OP_VADDR, 24'hFF_FFFF});
        send_cmd({dlcp_pkg::OP_BASE, 24'h04_0000});
        send_cmd({dlcp_pkg::OP_OFFSET, 24'h00_0000});
        send_cmd({dlcp_pkg::OP_VADDR, 24'h00_0010});
        send_cmd({dlcp_pkg::OP_BASE, 24'h08_0000});
        send_cmd({dlcp_pkg::OP_IADDR, 24'h00_0020});
        send_cmd({dlcp_pkg::OP_VTYPE, 24'hFF_FFFF});
        send_cmd({dlcp_pkg::OP_PRIM, 24'hFF_FFFF});
        send_cmd({dlcp_pkg::OP_VTYPE, 24'h00_0000});
        send_cmd({dlcp_pkg::OP_ORIGIN, 24'h00_0000});
        send_cmd({dlcp_pkg::OP_CALL, 24'h00_0103});
        send_cmd({dlcp_pkg::OP_JUMP, 24'hFF_FFFF});
        send_cmd({dlcp_pkg::OP_RET, 24'h00_0000});
        send_cmd({OP_COND_JUMP, 24'($urandom)});
        send_cmd({OP_UNUSED, 24'hFF_FFFF});
        send_cmd({dlcp_pkg::OP_END, 24'h00_0000});
        send_cmd({dlcp_pkg::OP_END, 24'h00_0000});
        start_list(32'h0800_0002);
        send_cmd(32'h0000_0000);
        send_cmd({dlcp_pkg::OP_END, 24'hFF_FFFF});
    endtask

    task automatic run_traffic(int amount);
        int goal;
        int shape;
        int depth;
        goal = sb.live_count + amount;
        while (sb.live_count < goal)
        begin
            shape = $urandom_range(0, 99);
            if (shape < 70)
            begin
                start_list(rand_start());
                repeat ($urandom_range(4, 40)) send_cmd(rand_command());
                if ($urandom_range(0, 4) != 0)
                    send_cmd({dlcp_pkg::OP_END, 24'($urandom)});
            end
            else if (shape < 80)
            begin
                // fill the call stack to near or past its limit, then unwind to or past empty
                start_list(rand_start());
                depth = $urandom_range(CALL_LIMIT - 2, CALL_LIMIT + 4);
                repeat (depth) send_cmd({dlcp_pkg::OP_CALL, 24'($urandom)});
                repeat (depth + $urandom_range(0, 2))
                    send_cmd({dlcp_pkg::OP_RET, 24'($urandom)});
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    send_request(($urandom_range(0, 4) != 0), $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_items();
        run_traffic(300);

        program_windows(32'h0400_0000, 32'h0420_0000, 32'h4400_0000, 32'h4500_0000);
        run_traffic(100);
        hold_request = 1'b1;
        run_traffic(200);

        program_windows(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        run_traffic(150);
        drain_results();
        run_traffic(150);

        program_windows(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0800_0000, 32'hFFFF_FFFF);
        run_traffic(250);

        program_windows({pick_top_byte(), 24'($urandom)}, {pick_top_byte(), 24'($urandom)},
                        {pick_top_byte(), 24'($urandom)}, {pick_top_byte(), 24'($urandom)});
        run_traffic(250);

        idle_on = 1'b0;
        program_windows(dlcp_pkg::VRAM_LOW_RESET, dlcp_pkg::VRAM_HIGH_RESET,
                        dlcp_pkg::MAIN_LOW_RESET, dlcp_pkg::MAIN_HIGH_RESET);
        run_traffic(350);

        in_valid <= 1'b0;
        end_wait = 0;
        while (sb.pending_results.size() != 0 && end_wait < END_LIMIT)
        begin
            @(posedge clk);
            end_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.pending_results.size() != 0)
            sb.report_error($sformatf("%0d results never arrived",
                                      sb.pending_results.size()));

        $display("ran %0d live requests: %0d list starts, %0d calls, %0d stack faults,",
                 sb.live_count, sb.start_count, sb.call_count, sb.fault_count);
        $display("%0d draws over %0d window settings, stalls on both sides, %0d-cycle hold",
                 sb.prim_count, window_settings, HOLD_CYCLES);
        if (sb.error_count == 0)
            $display("display_list_command_processor test passed");
        else
            $display("display_list_command_processor test failed");
        $finish;
    end

endmodule
